[hdl/pdc_pkg.sv]
// pdc_pkg: shared codes, widths and beat structs of the packet deframer.
// No dependencies; used by pdc_deframer and packet_deframer_checksum_unit.
package pdc_pkg;

  // Header layout: src, dst, type, seq lo/hi, len lo/hi, checksum lo/hi
  localparam int unsigned HeaderBytes = 9;
  localparam int unsigned HdrIdxW     = $clog2(HeaderBytes);
  localparam int unsigned SumBytes    = 7;
  localparam int unsigned HdrSrc      = 0;
  localparam int unsigned HdrDst      = 1;
  localparam int unsigned HdrKind     = 2;
  localparam int unsigned HdrSeqLo    = 3;
  localparam int unsigned HdrLenLo    = 5;
  localparam int unsigned HdrChkLo    = 7;

  // Input selector codes
  localparam logic [1:0] FnByte    = 2'd0;
  localparam logic [1:0] FnFail    = 2'd1;
  localparam logic [1:0] FnRestart = 2'd2;

  // Phase / status codes
  localparam logic [2:0] PhSeek    = 3'd0;
  localparam logic [2:0] PhHeader  = 3'd1;
  localparam logic [2:0] PhPayload = 3'd2;
  localparam logic [2:0] PhGood    = 3'd3;
  localparam logic [2:0] PhBad     = 3'd4;

  // Error codes
  localparam logic [1:0] ErrNone = 2'd0;
  localparam logic [1:0] ErrSum  = 2'd1;
  localparam logic [1:0] ErrSize = 2'd2;
  localparam logic [1:0] ErrRead = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CfgSyncFirst  = 2'd0;
  localparam logic [1:0] CfgSyncSecond = 2'd1;
  localparam logic [1:0] CfgMaxLength  = 2'd2;

  localparam logic [15:0] MaxLengthReset = 16'd1024;

  typedef struct packed {
    logic        en;
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  error_kind;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  source_id;
    logic [7:0]  destination_id;
    logic [7:0]  packet_kind;
    logic [15:0] sequence_id;
    logic [15:0] payload_length;
  } result_t;

endpackage

[hdl/pdc_deframer.sv]
// pdc_deframer: framing state, header store, checksum and per-beat result.
// Depends on pdc_pkg.
module pdc_deframer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pdc_pkg::cfg_wr_t cfg_i,
  input  logic             step_i,
  input  logic [1:0]       func_i,
  input  logic [7:0]       data_byte_i,
  output pdc_pkg::result_t result_o
);

  logic [7:0]  sync_first_q, sync_first_d;
  logic [7:0]  sync_second_q, sync_second_d;
  logic [15:0] max_length_q, max_length_d;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  prev_q, prev_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] sum_q, sum_d;
  logic [1:0]  err_q, err_d;

  logic [7:0]  hdr_q [pdc_pkg::HeaderBytes];
  logic [7:0]  hdr_d [pdc_pkg::HeaderBytes];

  logic        hdr_wr, hdr_clr;
  logic        pvalid;
  logic [7:0]  pbyte;
  logic [15:0] pindex;
  logic [15:0] byte_ext, len_q, chk_q, sum_inc, cnt_inc;

  // Configuration writes
  always_comb begin
    sync_first_d  = sync_first_q;
    sync_second_d = sync_second_q;
    max_length_d  = max_length_q;
    if (cfg_i.en) begin
      unique case (cfg_i.index)
        pdc_pkg::CfgSyncFirst:  sync_first_d  = cfg_i.data[7:0];
        pdc_pkg::CfgSyncSecond: sync_second_d = cfg_i.data[7:0];
        pdc_pkg::CfgMaxLength:  max_length_d  = cfg_i.data;
        default: ;
      endcase
    end
  end

  assign byte_ext = {8'h00, data_byte_i};
  assign len_q    = {hdr_q[pdc_pkg::HdrLenLo + 1], hdr_q[pdc_pkg::HdrLenLo]};
  assign chk_q    = {hdr_q[pdc_pkg::HdrChkLo + 1], hdr_q[pdc_pkg::HdrChkLo]};
  assign sum_inc  = sum_q + byte_ext;
  assign cnt_inc  = cnt_q + 16'd1;

  // Framing state update for one beat
  always_comb begin
    phase_d = phase_q;
    prev_d  = prev_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    err_d   = err_q;
    hdr_wr  = 1'b0;
    hdr_clr = 1'b0;
    pvalid  = 1'b0;
    pbyte   = 8'h00;
    pindex  = 16'h0000;
    if (step_i) begin
      case (func_i)
        pdc_pkg::FnFail: begin
          phase_d = pdc_pkg::PhBad;
          err_d   = pdc_pkg::ErrRead;
        end
        pdc_pkg::FnRestart: begin
          phase_d = pdc_pkg::PhSeek;
          prev_d  = 8'h00;
          cnt_d   = 16'h0000;
          sum_d   = 16'h0000;
          err_d   = pdc_pkg::ErrNone;
          hdr_clr = 1'b1;
        end
        pdc_pkg::FnByte: begin
          unique case (phase_q)
            pdc_pkg::PhSeek: begin
              // matching byte does not replace the previous byte
              if (prev_q == sync_first_q && data_byte_i == sync_second_q) begin
                phase_d = pdc_pkg::PhHeader;
                cnt_d   = 16'h0000;
                sum_d   = 16'h0000;
              end else begin
                prev_d = data_byte_i;
              end
            end
            pdc_pkg::PhHeader: begin
              hdr_wr = 1'b1;
              cnt_d  = cnt_inc;
              // checksum covers the header bytes ahead of the checksum field
              if (cnt_q < 16'(pdc_pkg::SumBytes)) sum_d = sum_inc;
              if (cnt_q == 16'(pdc_pkg::HeaderBytes - 1)) begin
                if (len_q <= max_length_q) begin
                  cnt_d = 16'h0000;
                  if (len_q == 16'h0000) begin
                    // empty payload: judge now, checksum high byte is this beat
                    if (16'({data_byte_i, hdr_q[pdc_pkg::HdrChkLo]} + sum_q) == 16'h0000)
                    begin
                      phase_d = pdc_pkg::PhGood;
                    end else begin
                      phase_d = pdc_pkg::PhBad;
                      err_d   = pdc_pkg::ErrSum;
                    end
                  end else begin
                    phase_d = pdc_pkg::PhPayload;
                  end
                end else begin
                  phase_d = pdc_pkg::PhBad;
                  err_d   = pdc_pkg::ErrSize;
                end
              end
            end
            pdc_pkg::PhPayload: begin
              sum_d  = sum_inc;
              pvalid = 1'b1;
              pbyte  = data_byte_i;
              pindex = cnt_q;
              cnt_d  = cnt_inc;
              if (cnt_inc == len_q) begin
                if (16'(chk_q + sum_inc) == 16'h0000) begin
                  phase_d = pdc_pkg::PhGood;
                end else begin
                  phase_d = pdc_pkg::PhBad;
                  err_d   = pdc_pkg::ErrSum;
                end
              end
            end
            default: ; // good and bad ignore bytes
          endcase
        end
        default: ;
      endcase
    end
  end

  // Header store next value: cleared on restart, written by position
  always_comb begin
    for (int i = 0; i < pdc_pkg::HeaderBytes; i++) begin
      if (hdr_clr) begin
        hdr_d[i] = 8'h00;
      end else if (hdr_wr && cnt_q[pdc_pkg::HdrIdxW-1:0] == pdc_pkg::HdrIdxW'(i)) begin
        hdr_d[i] = data_byte_i;
      end else begin
        hdr_d[i] = hdr_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= 8'h00;
      sync_second_q <= 8'h00;
      max_length_q  <= pdc_pkg::MaxLengthReset;
      phase_q       <= pdc_pkg::PhSeek;
      prev_q        <= 8'h00;
      cnt_q         <= 16'h0000;
      sum_q         <= 16'h0000;
      err_q         <= pdc_pkg::ErrNone;
    end else begin
      sync_first_q  <= sync_first_d;
      sync_second_q <= sync_second_d;
      max_length_q  <= max_length_d;
      phase_q       <= phase_d;
      prev_q        <= prev_d;
      cnt_q         <= cnt_d;
      sum_q         <= sum_d;
      err_q         <= err_d;
    end
  end

  // header bytes are payload: no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < pdc_pkg::HeaderBytes; i++) hdr_q[i] <= hdr_d[i];
  end

  // Result reflects the state after this beat
  always_comb begin
    result_o.status         = phase_d;
    result_o.error_kind     = (phase_d == pdc_pkg::PhBad) ? err_d : pdc_pkg::ErrNone;
    result_o.payload_valid  = pvalid;
    result_o.payload_byte   = pbyte;
    result_o.payload_index  = pindex;
    result_o.source_id      = hdr_d[pdc_pkg::HdrSrc];
    result_o.destination_id = hdr_d[pdc_pkg::HdrDst];
    result_o.packet_kind    = hdr_d[pdc_pkg::HdrKind];
    result_o.sequence_id    = {hdr_d[pdc_pkg::HdrSeqLo + 1], hdr_d[pdc_pkg::HdrSeqLo]};
    result_o.payload_length = {hdr_d[pdc_pkg::HdrLenLo + 1], hdr_d[pdc_pkg::HdrLenLo]};
  end

endmodule

[hdl/packet_deframer_checksum_unit.sv]
// packet_deframer_checksum_unit: top level, input beat register, output register.
// Depends on pdc_pkg and pdc_deframer.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------
//   in      | input     | in_valid_i / in_stall_o | func_i, data_byte_i
//   out     | output    | out_valid_o/out_stall_i | status_o .. payload_length_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One result beat per input beat; one beat per cycle sustained while out_stall_i is low.
// The input register holds each beat, then the deframer step is registered into the output register.
// Reset (rst_ni low, async) returns to sync hunt with default configuration.
// Output stall holds the output register; the input register keeps accepting while
// either register has room. Config writes are always ready.
module packet_deframer_checksum_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beats
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  data_byte_i,
  // result beats
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [1:0]  error_kind_o,
  output logic        payload_valid_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] payload_index_o,
  output logic [7:0]  source_id_o,
  output logic [7:0]  destination_id_o,
  output logic [7:0]  packet_kind_o,
  output logic [15:0] sequence_id_o,
  output logic [15:0] payload_length_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic             in_valid_q, in_valid_d;
  logic [1:0]       in_func_q;
  logic [7:0]       in_byte_q;
  logic             out_valid_q, out_valid_d;
  pdc_pkg::result_t res_q, res_step;
  pdc_pkg::cfg_wr_t cfg_wr;
  logic             out_room, advance, in_take;

  assign cfg_ready_o   = 1'b1;
  assign cfg_wr.en     = cfg_valid_i & cfg_ready_o;
  assign cfg_wr.index  = cfg_index_i;
  assign cfg_wr.data   = cfg_data_i;

  // Handshake between the two registers
  assign out_room   = ~out_valid_q | ~out_stall_i;
  assign advance    = in_valid_q & out_room;
  assign in_stall_o = in_valid_q & ~out_room;
  assign in_take    = in_valid_i & ~in_stall_o;
  assign in_valid_d = in_take | (in_valid_q & ~advance);
  assign out_valid_d = out_room ? advance : out_valid_q;

  pdc_deframer u_deframer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_wr),
    .step_i      (advance),
    .func_i      (in_func_q),
    .data_byte_i (in_byte_q),
    .result_o    (res_step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_func_q <= func_i;
      in_byte_q <= data_byte_i;
    end
    if (advance) res_q <= res_step;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = res_q.status;
  assign error_kind_o     = res_q.error_kind;
  assign payload_valid_o  = res_q.payload_valid;
  assign payload_byte_o   = res_q.payload_byte;
  assign payload_index_o  = res_q.payload_index;
  assign source_id_o      = res_q.source_id;
  assign destination_id_o = res_q.destination_id;
  assign packet_kind_o    = res_q.packet_kind;
  assign sequence_id_o    = res_q.sequence_id;
  assign payload_length_o = res_q.payload_length;

endmodule

[verif/packet_deframer_checksum_checker.sv]
`timescale 1ns / 100ps
// packet_deframer_checksum_checker: watches the input, result and config channels,
// predicts every result beat of the deframer and compares it with the DUT.
// Depends on pdc_pkg (codes and result_t); instantiated by packet_deframer_checksum_unit_tb.
module packet_deframer_checksum_checker
  import pdc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  func_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  result_t     result_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  // Configuration copy
  logic [7:0]  sync_first_q;
  logic [7:0]  sync_second_q;
  logic [15:0] max_len_q;

  // Deframer state copy
  logic [2:0]  phase_q;
  logic [7:0]  last_byte_q;
  logic [15:0] byte_cnt_q;
  logic [15:0] run_sum_q;
  logic [7:0]  hdr_q [HeaderBytes];
  logic [1:0]  err_q;

  result_t results_due [$];
  result_t want;
  int      mismatches;
  int      beat_num;

  function logic [15:0] hdr_word(int unsigned lo);
    return {hdr_q[HdrIdxW'(lo + 1)], hdr_q[HdrIdxW'(lo)]};
  endfunction

  // Back to sync hunt with an empty header
  function void clear_frame();
    phase_q     = PhSeek;
    last_byte_q = '0;
    byte_cnt_q  = '0;
    run_sum_q   = '0;
    err_q       = ErrNone;
    for (int i = 0; i < HeaderBytes; i++) hdr_q[i] = '0;
  endfunction

  // Good when checksum plus running sum wraps to zero
  function void judge_sum();
    logic [15:0] total;
    total = hdr_word(HdrChkLo) + run_sum_q;
    if (total == 16'h0000) begin
      phase_q = PhGood;
    end else begin
      phase_q = PhBad;
      err_q   = ErrSum;
    end
  endfunction

  // One input beat through the deframer; returns the result beat it causes
  function result_t step_frame(logic [1:0] fn, logic [7:0] b);
    result_t     r;
    logic [15:0] sum;
    r = '0;
    case (fn)
      FnFail: begin
        phase_q = PhBad;
        err_q   = ErrRead;
      end
      FnRestart: clear_frame();
      FnByte: begin
        case (phase_q)
          PhSeek: begin
            // the matching second byte does not become the previous byte
            if (last_byte_q == sync_first_q && b == sync_second_q) begin
              phase_q    = PhHeader;
              byte_cnt_q = '0;
              run_sum_q  = '0;
            end else begin
              last_byte_q = b;
            end
          end
          PhHeader: begin
            hdr_q[byte_cnt_q[HdrIdxW-1:0]] = b;
            byte_cnt_q++;
            if (byte_cnt_q >= 16'(HeaderBytes)) begin
              if (hdr_word(HdrLenLo) <= max_len_q) begin
                sum = run_sum_q;
                for (int i = 0; i < SumBytes; i++) sum += {8'h00, hdr_q[i]};
                run_sum_q  = sum;
                byte_cnt_q = '0;
                // empty payload is judged right away
                if (hdr_word(HdrLenLo) == 16'd0) judge_sum();
                else phase_q = PhPayload;
              end else begin
                phase_q = PhBad;
                err_q   = ErrSize;
              end
            end
          end
          PhPayload: begin
            run_sum_q       += {8'h00, b};
            r.payload_valid = 1'b1;
            r.payload_byte  = b;
            r.payload_index = byte_cnt_q;
            byte_cnt_q++;
            if (byte_cnt_q == hdr_word(HdrLenLo)) judge_sum();
          end
          default: ; // good and bad ignore bytes
        endcase
      end
      default: ; // unused selector
    endcase
    r.status         = phase_q;
    r.error_kind     = (phase_q == PhBad) ? err_q : ErrNone;
    r.source_id      = hdr_q[HdrSrc];
    r.destination_id = hdr_q[HdrDst];
    r.packet_kind    = hdr_q[HdrKind];
    r.sequence_id    = hdr_word(HdrSeqLo);
    r.payload_length = hdr_word(HdrLenLo);
    return r;
  endfunction

  function string fmt_result(result_t r);
    return $sformatf({"st=%0d err=%0d pv=%0d pb=%02h pi=%0d ",
                      "src=%02h dst=%02h kind=%02h seq=%04h len=%04h"},
                     r.status, r.error_kind, r.payload_valid, r.payload_byte, r.payload_index,
                     r.source_id, r.destination_id, r.packet_kind, r.sequence_id,
                     r.payload_length);
  endfunction

  // Channel monitor: config, prediction on input beats, compare on result beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  = '0;
      sync_second_q = '0;
      max_len_q     = MaxLengthReset;
      clear_frame();
      results_due.delete();
      mismatches    = 0;
      beat_num      = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgSyncFirst:  sync_first_q  = cfg_data_i[7:0];
          CfgSyncSecond: sync_second_q = cfg_data_i[7:0];
          CfgMaxLength:  max_len_q     = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) results_due.push_back(step_frame(func_i, data_byte_i));
      if (out_valid_i && !out_stall_i) begin
        if (results_due.size() == 0) begin
          if (mismatches < 10)
            $display("result beat %0d with nothing pending: %s", beat_num,
                     fmt_result(result_i));
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (result_i !== want) begin
            if (mismatches < 10)
              $display("result beat %0d mismatch\n  exp %s\n  got %s", beat_num,
                       fmt_result(want), fmt_result(result_i));
            mismatches++;
          end
        end
        beat_num++;
      end
      fail_count_o <= mismatches;
      pending_o    <= results_due.size();
    end
  end

endmodule

[verif/packet_deframer_checksum_unit_tb.sv]
`timescale 1ns / 100ps
// packet_deframer_checksum_unit_tb: stimulus and verdict for the packet deframer.
// Depends on pdc_pkg, packet_deframer_checksum_unit and packet_deframer_checksum_checker.
module packet_deframer_checksum_unit_tb;
  import pdc_pkg::*;

  localparam logic [1:0] FnIdle     = 2'd3; // unused selector, changes nothing
  localparam int         CycleLimit = 400000;
  localparam int         PhaseItems = 230;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic [1:0]  func      = FnByte;
  logic [7:0]  data_byte = '0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = CfgSyncFirst;
  logic [15:0] cfg_data  = '0;

  logic        in_stall;
  logic        out_valid;
  logic [2:0]  status;
  logic [1:0]  error_kind;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic [7:0]  source_id;
  logic [7:0]  destination_id;
  logic [7:0]  packet_kind;
  logic [15:0] sequence_id;
  logic [15:0] payload_length;
  logic        cfg_ready;

  int          fail_count;
  int          pending;
  int          cycles     = 0;
  int          items_sent = 0;
  int          idle_pct   = 0;
  int          stall_pct  = 0;

  // Local copy of the programmed config, used to shape frames
  logic [7:0]  sync_a  = '0;
  logic [7:0]  sync_b  = '0;
  logic [15:0] max_len = MaxLengthReset;

  packet_deframer_checksum_unit dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .func_i           (func),
    .data_byte_i      (data_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status),
    .error_kind_o     (error_kind),
    .payload_valid_o  (payload_valid),
    .payload_byte_o   (payload_byte),
    .payload_index_o  (payload_index),
    .source_id_o      (source_id),
    .destination_id_o (destination_id),
    .packet_kind_o    (packet_kind),
    .sequence_id_o    (sequence_id),
    .payload_length_o (payload_length),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  packet_deframer_checksum_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .func_i       (func),
    .data_byte_i  (data_byte),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .result_i     ({status, error_kind, payload_valid, payload_byte, payload_index,
                    source_id, destination_id, packet_kind, sequence_id, payload_length}),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver backpressure
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("packet_deframer_checksum_unit_tb: FAIL");
      $finish;
    end
  end

  // One input beat, with a random idle gap ahead of it
  task automatic send_beat(input logic [1:0] fn, input logic [7:0] b);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid  <= 1'b1;
    func      <= fn;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Hold off the sender until every result beat is back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic cfg_beat(input logic [1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all three registers; upper bits of the sync writes carry junk
  task automatic program_regs(input logic [7:0] sf, ss, input logic [15:0] ml);
    logic [15:0] junk;
    junk = 16'($urandom);
    cfg_beat(CfgSyncFirst, {junk[15:8], sf});
    cfg_beat(CfgSyncSecond, {junk[7:0], ss});
    cfg_beat(CfgMaxLength, ml);
    cfg_valid <= 1'b0;
    sync_a  = sf;
    sync_b  = ss;
    max_len = ml;
  endtask

  // Header plus payload; optionally replaces beat abort_at with abort_fn
  task automatic send_frame(input logic [7:0] src, dst, kind, input logic [15:0] seq, len,
                            input bit bad_sum, input int abort_at, input logic [1:0] abort_fn);
    logic [7:0]  hdr [HeaderBytes];
    logic [7:0]  body [64];
    logic [15:0] sum;
    int          n_body;
    n_body = (len <= max_len && len <= 16'd64) ? int'(len) : 0;
    hdr[HdrSrc]     = src;
    hdr[HdrDst]     = dst;
    hdr[HdrKind]    = kind;
    hdr[HdrSeqLo]   = seq[7:0];
    hdr[HdrSeqLo+1] = seq[15:8];
    hdr[HdrLenLo]   = len[7:0];
    hdr[HdrLenLo+1] = len[15:8];
    sum = '0;
    for (int i = 0; i < SumBytes; i++) sum += {8'h00, hdr[i]};
    for (int i = 0; i < n_body; i++) begin
      body[i] = 8'($urandom);
      sum += {8'h00, body[i]};
    end
    sum = -sum;
    if (bad_sum) sum = sum + 16'($urandom_range(1, 65535));
    hdr[HdrChkLo]   = sum[7:0];
    hdr[HdrChkLo+1] = sum[15:8];
    for (int i = 0; i < HeaderBytes + n_body; i++) begin
      if (i == abort_at) begin
        send_beat(abort_fn, 8'($urandom));
        return;
      end
      // now and then let everything drain mid-header
      if (i == 4 && $urandom_range(0, 19) == 0) drain_results();
      if ($urandom_range(0, 99) < 2) send_beat(FnIdle, 8'($urandom));
      send_beat(FnByte, (i < HeaderBytes) ? hdr[i] : body[i - HeaderBytes]);
    end
  endtask

  // Noise, sync pair, frame with random content, trailing bytes, restart
  task automatic send_random_frame();
    int          r;
    int          cap;
    int          abort_at;
    logic [15:0] len;
    repeat ($urandom_range(0, 3))
      send_beat(($urandom_range(0, 19) == 0) ? FnIdle : FnByte, 8'($urandom));
    send_beat(FnByte, sync_a);
    send_beat(FnByte, sync_b);
    cap = (max_len < 16'd12) ? int'(max_len) : 12;
    r = $urandom_range(0, 99);
    if (r < 12 && max_len != 16'hFFFF)
      len = (r < 6) ? 16'($urandom_range(int'(max_len) + 1, 65535)) : max_len + 16'd1;
    else if (r < 18 && max_len <= 16'd40)
      len = max_len;
    else
      len = 16'($urandom_range(0, cap));
    abort_at = ($urandom_range(0, 99) < 8) ? int'($urandom_range(0, HeaderBytes + cap)) : -1;
    send_frame(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), len,
               $urandom_range(0, 99) < 20, abort_at,
               $urandom_range(0, 1) ? FnFail : FnRestart);
    repeat ($urandom_range(0, 2)) send_beat(FnByte, 8'($urandom));
    send_beat(FnRestart, 8'($urandom));
  endtask

  task automatic run_phase(input int idle, stall, input logic [7:0] sf, ss,
                           input logic [15:0] ml);
    int stop_at;
    drain_results();
    idle_pct  = idle;
    stall_pct = stall;
    program_regs(sf, ss, ml);
    stop_at = items_sent + PhaseItems;
    while (items_sent < stop_at) send_random_frame();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, reset config (sync 00 00, max length 1024).
    // Header store has no reset value: a restart clears it before anything else.
    send_beat(FnRestart, 8'h00);
    send_beat(FnIdle, 8'hFF);
    send_beat(FnByte, 8'h00);   // previous byte is zero, so this completes sync
    send_frame(8'hFF, 8'h00, 8'h80, 16'hFFFF, 16'd1, 1'b0, -1, FnFail);
    send_beat(FnByte, 8'h5C);   // ignored after a good packet
    send_beat(FnFail, 8'h00);   // read failure
    send_beat(FnByte, 8'hFF);   // ignored while bad
    send_beat(FnRestart, 8'h00);
    send_beat(FnByte, 8'h00);
    // empty payload with a broken checksum
    send_frame(8'h01, 8'hFE, 8'h7F, 16'h0000, 16'd0, 1'b1, -1, FnFail);

    // Random part across configs and idle patterns
    run_phase(0, 0, 8'hA5, 8'h5A, 16'd16);
    run_phase(76, 0, 8'hFF, 8'h00, 16'd0);
    run_phase(0, 76, 8'h00, 8'hFF, 16'hFFFF);
    run_phase(27, 27, 8'h33, 8'h33, 16'd8);
    run_phase(0, 0, 8'($urandom), 8'($urandom), 16'($urandom_range(0, 40)));

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("packet_deframer_checksum_unit_tb: PASS");
    end else begin
      $display("packet_deframer_checksum_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
